// ===== sv/hid_keyboard_report_builder_macros.svh =====
// Assertion macros shared by the report builder RTL.
// Both macros sample on clk and stay quiet while rst_n is low.
`ifndef HID_KEYBOARD_REPORT_BUILDER_MACROS_SVH
`define HID_KEYBOARD_REPORT_BUILDER_MACROS_SVH
`ifndef SYNTHESIS
`define HKRB_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hkrb assertion failed");
`define HKRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hkrb assertion failed");
`else
`define HKRB_ASSERT_IMPLY(label, ante, cons)
`define HKRB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/hkrb_pkg.sv =====
`default_nettype none
package hkrb_pkg;

    localparam int NUM_SLOTS = 6;
    localparam int OUT_SLOTS = 6;
    localparam int SLOT_W    = 7;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    localparam logic [1:0] REQ_PRESS       = 2'd0;
    localparam logic [1:0] REQ_RELEASE     = 2'd1;
    localparam logic [1:0] REQ_RELEASE_ALL = 2'd2;

    localparam logic [7:0] MOD_BASE   = 8'd128;
    localparam logic [7:0] RAW_BASE   = 8'd136;
    localparam logic [7:0] LEFT_SHIFT = 8'h02;
    localparam int         SHIFT_BIT  = 7;

    typedef logic [SLOT_W-1:0] slot_t;

    // Decoded request handed from the decoder to the engine
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] mod_mask;
        logic       slot_act;
        slot_t      usage;
    } dec_t;

    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

    typedef struct packed {
        logic [7:0]                         modifier;
        logic [OUT_SLOTS-1:0][SLOT_W-1:0]   slots;
    } rpt_t;

    // ASCII to usage map; bit 7 marks a shifted character
    localparam logic [7:0] ASCII_ROM [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
        8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
        8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
        8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
        8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
        8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
        8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
        8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
        8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
        8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
        8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
        8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
    };

endpackage
`default_nettype wire

// ===== sv/hkrb_req_if.sv =====
`default_nettype none
interface hkrb_req_if
    import hkrb_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] key_code;

    modport source (output valid, output req_type, output key_code, input ready);
    modport sink   (input valid, input req_type, input key_code, output ready);
endinterface
`default_nettype wire

// ===== sv/hkrb_rpt_if.sv =====
`default_nettype none
interface hkrb_rpt_if
    import hkrb_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [7:0]  modifier_bits;
    slot_t       slot_0;
    slot_t       slot_1;
    slot_t       slot_2;
    slot_t       slot_3;
    slot_t       slot_4;
    slot_t       slot_5;

    modport source (
        output valid, output modifier_bits,
        output slot_0, output slot_1, output slot_2,
        output slot_3, output slot_4, output slot_5,
        input ready
    );
    modport sink (
        input valid, input modifier_bits,
        input slot_0, input slot_1, input slot_2,
        input slot_3, input slot_4, input slot_5,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/hid_keyboard_report_builder.sv =====
// A request accepted in idle passes through the scan state (press or release with a slot usage), then
// the done state, where it waits until the output register is free, and then the output register. The
// single slot comparator visits one slot per cycle during a press or release; no new request is taken until idle.
// Modifier-only, release-all and ignored requests skip the scan and go straight to the done state.
// Reset (rst_n low, asynchronous) clears the modifier byte, all slots and the output valid.
`default_nettype none
`include "hid_keyboard_report_builder_macros.svh"
module hid_keyboard_report_builder
    import hkrb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    hkrb_req_if.sink      req,
    hkrb_rpt_if.source    rpt
);

    dec_t      dec;
    eng_stat_t stat;
    rpt_t      report;
    logic      start;
    logic      res_free;
    logic      load;

    logic      out_valid_reg, out_valid_next;
    rpt_t      rpt_data_reg;

    // Decode the key code: ROM lookup for characters, bit mask for modifiers,
    // offset removal for raw usages.
    hkrb_decode u_decode (
        .req_type (req.req_type),
        .key_code (req.key_code),
        .dec      (dec)
    );

    // Take a new request only while the sequencer sits idle.
    assign req.ready = stat.idle;
    assign start     = req.valid && req.ready;

    // The output register is free when empty or when its report is taken this cycle.
    assign res_free = !out_valid_reg || rpt.ready;
    assign load     = stat.done && res_free;

    // Sequencer, slot store and the shared slot comparator.
    hkrb_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dec      (dec),
        .res_free (res_free),
        .stat     (stat),
        .report   (report)
    );

    // Output stage: hold the finished report until the sink takes it.
    assign out_valid_next = load || (out_valid_reg && !rpt.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rpt_data_reg <= report;
    end

    assign rpt.valid         = out_valid_reg;
    assign rpt.modifier_bits = rpt_data_reg.modifier;
    assign rpt.slot_0        = rpt_data_reg.slots[0];
    assign rpt.slot_1        = rpt_data_reg.slots[1];
    assign rpt.slot_2        = rpt_data_reg.slots[2];
    assign rpt.slot_3        = rpt_data_reg.slots[3];
    assign rpt.slot_4        = rpt_data_reg.slots[4];
    assign rpt.slot_5        = rpt_data_reg.slots[5];

    `HKRB_ASSERT_NEXT(a_busy_after_accept, start, !req.ready)
    `HKRB_ASSERT_NEXT(a_done_holds, stat.done && !res_free, stat.done)
    `HKRB_ASSERT_NEXT(a_load_sets_valid, load, out_valid_reg)

endmodule
`default_nettype wire

// ===== sv/hkrb_decode.sv =====
`default_nettype none
module hkrb_decode
    import hkrb_pkg::*;
(
    input  wire logic [1:0] req_type,
    input  wire logic [7:0] key_code,
    output dec_t            dec
);

    logic [7:0] rom_entry;

    assign rom_entry = ASCII_ROM[key_code[6:0]];

    always_comb
    begin
        dec.op       = req_type;
        dec.mod_mask = '0;
        dec.usage    = '0;
        dec.slot_act = 1'b0;
        if (key_code >= RAW_BASE)
        begin
            dec.usage    = SLOT_W'(key_code - RAW_BASE);
            dec.slot_act = (dec.usage != '0);
        end
        else if (key_code >= MOD_BASE)
        begin
            dec.mod_mask = 8'(8'd1 << key_code[2:0]);
        end
        else if (rom_entry != '0)
        begin
            // shifted characters drive left shift
            dec.mod_mask = rom_entry[SHIFT_BIT] ? LEFT_SHIFT : 8'h00;
            dec.usage    = rom_entry[SLOT_W-1:0];
            dec.slot_act = (dec.usage != '0);
        end
    end

endmodule
`default_nettype wire

// ===== sv/hkrb_engine.sv =====
`default_nettype none
`include "hid_keyboard_report_builder_macros.svh"
module hkrb_engine
    import hkrb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire dec_t  dec,
    input  wire logic  res_free,
    output eng_stat_t  stat,
    output rpt_t       report
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    slot_t            usage_reg, usage_next;
    logic             press_reg, press_next;
    logic             found_reg, found_next;
    logic             empty_ok_reg, empty_ok_next;
    logic [IDX_W-1:0] empty_idx_reg, empty_idx_next;
    logic [7:0]       modifier_reg, modifier_next;
    slot_t            slots_reg [NUM_SLOTS];
    slot_t            slots_next [NUM_SLOTS];

    // shared compare unit: one slot per cycle against the held usage
    slot_t cur_slot;
    logic  hit;
    logic  empty;
    logic  last;

    assign cur_slot = slots_reg[idx_reg];
    assign hit      = (cur_slot == usage_reg);
    assign empty    = (cur_slot == '0);
    assign last     = (idx_reg == LAST_IDX);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        usage_next     = usage_reg;
        press_next     = press_reg;
        found_next     = found_reg;
        empty_ok_next  = empty_ok_reg;
        empty_idx_next = empty_idx_reg;
        modifier_next  = modifier_reg;
        slots_next     = slots_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next    = ST_DONE;
                    idx_next      = '0;
                    usage_next    = dec.usage;
                    press_next    = (dec.op == REQ_PRESS);
                    found_next    = 1'b0;
                    empty_ok_next = 1'b0;
                    case (dec.op)
                        REQ_PRESS:
                        begin
                            modifier_next = modifier_reg | dec.mod_mask;
                            if (dec.slot_act)
                                state_next = ST_SCAN;
                        end
                        REQ_RELEASE:
                        begin
                            modifier_next = modifier_reg & ~dec.mod_mask;
                            if (dec.slot_act)
                                state_next = ST_SCAN;
                        end
                        REQ_RELEASE_ALL:
                        begin
                            modifier_next = '0;
                            for (int i = 0; i < NUM_SLOTS; i++)
                                slots_next[i] = '0;
                        end
                        default:
                        begin
                            modifier_next = modifier_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (press_reg)
                begin
                    found_next = found_reg | hit;
                    if (empty && !empty_ok_reg)
                    begin
                        empty_ok_next  = 1'b1;
                        empty_idx_next = idx_reg;
                    end
                    if (last && !found_next && empty_ok_next)
                        slots_next[empty_idx_next] = usage_reg;
                end
                else if (hit)
                begin
                    slots_next[idx_reg] = '0;
                end
                if (last)
                    state_next = ST_DONE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (res_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            modifier_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                slots_reg[i] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            modifier_reg <= modifier_next;
            slots_reg    <= slots_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        usage_reg     <= usage_next;
        press_reg     <= press_next;
        found_reg     <= found_next;
        empty_ok_reg  <= empty_ok_next;
        empty_idx_reg <= empty_idx_next;
    end

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);

    assign report.modifier = modifier_reg;
    for (genvar j = 0; j < OUT_SLOTS; j++)
    begin : g_out
        if (j < NUM_SLOTS)
        begin : g_used
            assign report.slots[j] = slots_reg[j];
        end
        else
        begin : g_pad
            assign report.slots[j] = '0;
        end
    end

    `HKRB_ASSERT_NEXT(a_rel_all_clears, start && stat.idle && dec.op == REQ_RELEASE_ALL, modifier_reg == 8'h00)
    `HKRB_ASSERT_IMPLY(a_idx_range, state_reg == ST_SCAN, idx_reg <= LAST_IDX)
    `HKRB_ASSERT_NEXT(a_scan_ends, state_reg == ST_SCAN && last, state_reg == ST_DONE)

endmodule
`default_nettype wire

// ===== verif/hkrb_report_checker.sv =====
`timescale 1ns / 1ps
module hkrb_report_checker
    import hkrb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hkrb_req_if         req_mon,
    hkrb_rpt_if         rpt_mon,
    output int unsigned fail_count,
    output int unsigned reports_due
);

    logic [7:0]  held_mods;
    slot_t       held_keys [NUM_SLOTS];
    rpt_t        due_reports [$];
    int unsigned fault_tally;
    int unsigned report_number;

    task automatic log_fault(input string msg);
        begin
            fault_tally++;
            if (fault_tally <= 10)
            begin
                $display("%0t: %s", $realtime, msg);
            end
        end
    endtask

    // Update the held modifier byte and key slots for one key event.
    task automatic apply_key_event(input logic [1:0] kind, input logic [7:0] code);
        logic [7:0] rom_entry;
        logic [7:0] mod_mask;
        slot_t      usage;
        logic       pressing;
        logic       mapped;
        logic       placed;
        begin
            pressing = (kind == REQ_PRESS);
            mapped   = 1'b1;
            usage    = '0;
            if (kind == REQ_RELEASE_ALL)
            begin
                held_mods = '0;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    held_keys[i] = '0;
                end
            end
            else if (kind == REQ_PRESS || kind == REQ_RELEASE)
            begin
                if (code >= RAW_BASE)
                begin
                    usage = slot_t'(code - RAW_BASE);
                end
                else if (code >= MOD_BASE)
                begin
                    mod_mask = 8'd1 << code[2:0];
                    if (pressing)
                        held_mods = held_mods | mod_mask;
                    else
                        held_mods = held_mods & ~mod_mask;
                end
                else
                begin
                    rom_entry = ASCII_ROM[code[6:0]];
                    if (rom_entry == 8'h00)
                    begin
                        mapped = 1'b0;
                    end
                    else
                    begin
                        if (rom_entry[SHIFT_BIT])
                        begin
                            if (pressing)
                                held_mods = held_mods | LEFT_SHIFT;
                            else
                                held_mods = held_mods & ~LEFT_SHIFT;
                        end
                        usage = rom_entry[SLOT_W-1:0];
                    end
                end
                if (mapped && usage != '0)
                begin
                    if (pressing)
                    begin
                        // drop a key already held, else take the lowest free slot
                        placed = 1'b0;
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (held_keys[i] == usage)
                                placed = 1'b1;
                        end
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (!placed && held_keys[i] == '0)
                            begin
                                held_keys[i] = usage;
                                placed = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (held_keys[i] == usage)
                                held_keys[i] = '0;
                        end
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rpt_t seen;
        rpt_t want;
        if (!rst_n)
        begin
            held_mods = '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                held_keys[i] = '0;
            end
            due_reports.delete();
            fault_tally   = 0;
            report_number = 0;
        end
        else
        begin
            // check the report leaving first; a request cannot come back in the same edge
            if (rpt_mon.valid && rpt_mon.ready)
            begin
                seen.modifier = rpt_mon.modifier_bits;
                seen.slots[0] = rpt_mon.slot_0;
                seen.slots[1] = rpt_mon.slot_1;
                seen.slots[2] = rpt_mon.slot_2;
                seen.slots[3] = rpt_mon.slot_3;
                seen.slots[4] = rpt_mon.slot_4;
                seen.slots[5] = rpt_mon.slot_5;
                if (due_reports.size() == 0)
                begin
                    log_fault($sformatf("report %0d arrived with no request pending",
                                        report_number));
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (seen.modifier !== want.modifier)
                        log_fault($sformatf("report %0d modifier_bits: expected %02h, got %02h",
                                            report_number, want.modifier, seen.modifier));
                    for (int j = 0; j < OUT_SLOTS; j++)
                    begin
                        if (seen.slots[j] !== want.slots[j])
                            log_fault($sformatf("report %0d slot_%0d: expected %02h, got %02h",
                                                report_number, j, want.slots[j],
                                                seen.slots[j]));
                    end
                end
                report_number++;
            end
            if (req_mon.valid && req_mon.ready)
            begin
                apply_key_event(req_mon.req_type, req_mon.key_code);
                want.modifier = held_mods;
                for (int j = 0; j < OUT_SLOTS; j++)
                begin
                    want.slots[j] = (j < NUM_SLOTS) ? held_keys[j] : slot_t'(0);
                end
                due_reports.push_back(want);
            end
        end
        fail_count  <= fault_tally;
        reports_due <= due_reports.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import hkrb_pkg::*;

    localparam int RX_HOLD_CYCLES = 300;
    localparam int RANDOM_PER_PHASE = 375;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hkrb_req_if req_ch ();
    hkrb_rpt_if rpt_ch ();

    int unsigned fail_count;
    int unsigned reports_due;

    // idle odds in percent, changed only at clock edges
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    // a long receiver hold-off runs whenever requests exceed those served
    int hold_requests = 0;
    int hold_served   = 0;

    // codes pressed and not yet released, used to aim releases at held keys
    logic [7:0] pressed_codes [$];

    hid_keyboard_report_builder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rpt   (rpt_ch)
    );

    hkrb_report_checker report_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_mon     (req_ch),
        .rpt_mon     (rpt_ch),
        .fail_count  (fail_count),
        .reports_due (reports_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: stall at random, or hold off for a long stretch on request.
    initial
    begin
        rpt_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served++;
                rpt_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                rpt_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one request; return at the edge that accepts it, valid still high.
    task automatic send_key_event(input logic [1:0] kind, input logic [7:0] code);
        begin
            // drop valid only when a gap is actually taken, so valid never toggles twice
            if ($urandom_range(99) < tx_idle_pct)
            begin
                req_ch.valid <= 1'b0;
                do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
            end
            req_ch.valid    <= 1'b1;
            req_ch.req_type <= kind;
            req_ch.key_code <= code;
            do @(posedge clk); while (!req_ch.ready);
        end
    endtask

    // Hold the input quiet until every report owed has come out.
    task automatic drain_reports();
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while (reports_due != 0);
        end
    endtask

    function automatic logic [7:0] random_key_code();
        int pick;
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                return 8'($urandom_range(126, 32));     // printable characters
            else if (pick < 65)
                return 8'($urandom_range(135, 128));    // modifier keys
            else if (pick < 90)
                return 8'($urandom_range(255, 136));    // raw usages
            else
                return 8'($urandom_range(255, 0));
        end
    endfunction

    // Mostly realistic typing: presses, releases of held keys, now and then
    // a release-all; a little noise with stray releases and the unused type.
    task automatic random_key_event();
        int         pick;
        int         idx;
        logic [7:0] code;
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                code = random_key_code();
                if (pressed_codes.size() < 12)
                    pressed_codes.push_back(code);
                send_key_event(REQ_PRESS, code);
            end
            else if (pick < 85)
            begin
                if (pressed_codes.size() != 0 && $urandom_range(3) != 0)
                begin
                    idx  = $urandom_range(pressed_codes.size() - 1);
                    code = pressed_codes[idx];
                    pressed_codes.delete(idx);
                end
                else
                begin
                    code = random_key_code();
                end
                send_key_event(REQ_RELEASE, code);
            end
            else if (pick < 92)
            begin
                pressed_codes.delete();
                send_key_event(REQ_RELEASE_ALL, 8'($urandom));
            end
            else if (pick < 96)
            begin
                send_key_event(2'b11, 8'($urandom));
            end
            else
            begin
                send_key_event(2'($urandom), 8'($urandom));
            end
        end
    endtask

    initial
    begin
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_PRESS;
        req_ch.key_code <= 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: shifted and plain forms of one key, modifiers, usage zero,
        // unmapped characters, full slots, release of a shifted character,
        // the unused request type and release-all.
        send_key_event(REQ_PRESS, 8'h61);           // 'a'
        send_key_event(REQ_PRESS, 8'h41);           // 'A': same usage, sets shift only
        send_key_event(REQ_PRESS, MOD_BASE);        // lowest modifier bit
        send_key_event(REQ_PRESS, 8'd135);          // highest modifier bit
        send_key_event(REQ_PRESS, RAW_BASE);        // usage zero, no slot
        send_key_event(REQ_PRESS, 8'hFF);           // highest raw usage
        send_key_event(REQ_PRESS, 8'h00);           // unmapped
        send_key_event(REQ_PRESS, 8'h7F);           // unmapped
        send_key_event(REQ_PRESS, 8'h31);           // '1'
        send_key_event(REQ_PRESS, 8'h20);           // space
        send_key_event(REQ_PRESS, 8'h0A);           // enter
        send_key_event(REQ_PRESS, 8'h7A);           // 'z' fills the last slot
        send_key_event(REQ_PRESS, 8'h62);           // 'b' with slots full: dropped
        send_key_event(REQ_RELEASE, 8'h41);         // frees 'a' slot, clears shift
        send_key_event(REQ_PRESS, 8'h62);           // 'b' takes the freed slot
        send_key_event(REQ_PRESS, 8'h21);           // '!' while full: shift still set
        send_key_event(REQ_RELEASE, 8'd135);
        send_key_event(REQ_RELEASE, MOD_BASE);
        send_key_event(REQ_RELEASE, 8'h00);         // unmapped release
        send_key_event(REQ_RELEASE, RAW_BASE);      // usage zero release
        send_key_event(REQ_RELEASE, 8'hFF);
        send_key_event(2'b11, 8'hAA);               // unused type
        send_key_event(2'b11, 8'h55);
        send_key_event(REQ_RELEASE_ALL, 8'hFF);
        send_key_event(REQ_RELEASE_ALL, 8'h00);

        // Sender mostly busy, receiver mostly stalled.
        tx_idle_pct <= 14;
        rx_idle_pct <= 71;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            random_key_event();

        // Pause the sender until the block has emptied.
        drain_reports();

        // Sender mostly idle, receiver mostly ready.
        tx_idle_pct <= 71;
        rx_idle_pct <= 14;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            random_key_event();

        // Full rate both ways; partway through, stall the receiver for a long
        // stretch while requests keep coming so the input backs up.
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            if (n == 50)
                hold_requests <= hold_requests + 1;
            random_key_event();
        end

        drain_reports();
        repeat (NUM_SLOTS + 6) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
